@@ rtl/core/rmze_pkg.sv @@
// Shared types, constants and job-setup functions for the ZYX Euler angle converter.
package rmze_pkg;

    // Widths that cover every legal parameter value
    localparam int XW = 34;           // arctangent operand width (matrix entry + sign growth)
    localparam int ZW = 36;           // angle accumulator, radians * 2^30
    localparam int CW = 64;           // CORDIC vector width after prescale
    localparam int ZFRAC = 30;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [ZW-1:0] PI_Z  = 36'sd3373259426;
    localparam logic signed [ZW-1:0] PIH_Z = 36'sd1686629713;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd0
    };

    // One arctangent request: either a fixed angle (bypass) or CORDIC(x, y) + base
    typedef struct packed {
        logic                 bypass;
        logic signed [ZW-1:0] base;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
    } atan_job_t;

    typedef struct packed {
        atan_job_t yaw;
        atan_job_t pitch;
        atan_job_t roll;
        logic      lock;
    } euler_req_t;

    typedef struct packed {
        logic                 bypass;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_lane_t;

    function automatic atan_job_t fixed_job(input logic signed [ZW-1:0] angle);
        atan_job_t j;
        j.bypass = 1'b1;
        j.base   = angle;
        j.x      = '0;
        j.y      = '0;
        return j;
    endfunction

    function automatic atan_job_t full_atan2_job(input logic signed [XW-1:0] y,
                                                 input logic signed [XW-1:0] x);
        atan_job_t j;
        j = fixed_job('0);
        if (x == 0)
        begin
            j.base = (y > 0) ? PIH_Z : ((y < 0) ? -PIH_Z : '0);
        end
        else if (y == 0)
        begin
            j.base = (x > 0) ? '0 : PI_Z;
        end
        else if (x > 0)
        begin
            j.bypass = 1'b0;
            j.x      = x;
            j.y      = y;
        end
        else
        begin
            j.bypass = 1'b0;
            j.x      = -x;
            j.y      = -y;
            j.base   = (y > 0) ? PI_Z : -PI_Z;
        end
        return j;
    endfunction

    function automatic atan_job_t half_atan_job(input logic signed [XW-1:0] n,
                                                input logic signed [XW-1:0] d);
        atan_job_t j;
        if (d == 0)
        begin
            j = fixed_job((n > 0) ? PIH_Z : ((n < 0) ? -PIH_Z : '0));
        end
        else if (d > 0)
        begin
            j = full_atan2_job(n, d);
        end
        else
        begin
            j = full_atan2_job(-n, -d);
        end
        return j;
    endfunction

endpackage

@@ rtl/core/rmze_front.sv @@
// Front end: capture a matrix, pick the branch, set up the arctangent requests, run asin's sqrt.
module rmze_front
    import rmze_pkg::*;
#(
    parameter int MATRIX_WIDTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic signed [MATRIX_WIDTH-1:0] r00,
    input  logic signed [MATRIX_WIDTH-1:0] r01,
    input  logic signed [MATRIX_WIDTH-1:0] r10,
    input  logic signed [MATRIX_WIDTH-1:0] r11,
    input  logic signed [MATRIX_WIDTH-1:0] r20,
    input  logic signed [MATRIX_WIDTH-1:0] r21,
    input  logic signed [MATRIX_WIDTH-1:0] r22,
    output logic                           req_valid,
    output euler_req_t                     req
);

    localparam int M  = MATRIX_WIDTH;
    localparam int VW = 2 * M - 3;     // radicand width
    localparam int RW = M - 1;         // root width
    localparam int NS = M - 1;         // one root bit per stage
    localparam logic signed [M-1:0] ONE = M'(1) <<< (M - 2);
    localparam logic [VW-1:0] ONE_SQ = VW'(1) << (2 * M - 4);

    // capture stage
    logic                  a_valid_reg;
    logic signed [M-1:0]   a_r00_reg, a_r01_reg, a_r10_reg, a_r11_reg;
    logic signed [M-1:0]   a_r20_reg, a_r21_reg, a_r22_reg;

    // classify stage
    logic                  b_valid_reg;
    logic [2*M-1:0]        b_ss_reg;
    logic                  b_lock_reg;
    logic                  b_pneg_reg;
    logic signed [XW-1:0]  b_s_reg;
    atan_job_t             b_yaw_reg, b_roll_reg;

    logic signed [2*M-1:0] ss_next;
    logic                  lock_next;
    atan_job_t             yaw_next, roll_next;

    // square root stages
    logic                  q_valid_reg [NS+1];
    logic [VW-1:0]         q_rem_reg   [NS+1];
    logic [RW-1:0]         q_root_reg  [NS+1];
    logic                  q_lock_reg  [NS+1];
    logic                  q_pneg_reg  [NS+1];
    logic signed [XW-1:0]  q_s_reg     [NS+1];
    atan_job_t             q_yaw_reg   [NS+1];
    atan_job_t             q_roll_reg  [NS+1];

    logic                  req_valid_reg;
    euler_req_t            req_reg;
    euler_req_t            req_next;

    always_comb
    begin
        ss_next   = a_r20_reg * a_r20_reg;
        lock_next = !((a_r20_reg > -ONE) && (a_r20_reg < ONE));
        if (lock_next)
        begin
            yaw_next  = half_atan_job(-XW'(a_r01_reg), XW'(a_r11_reg));
            roll_next = fixed_job('0);
        end
        else
        begin
            yaw_next  = full_atan2_job(XW'(a_r10_reg), XW'(a_r00_reg));
            roll_next = half_atan_job(XW'(a_r21_reg), XW'(a_r22_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_r00_reg <= r00;
            a_r01_reg <= r01;
            a_r10_reg <= r10;
            a_r11_reg <= r11;
            a_r20_reg <= r20;
            a_r21_reg <= r21;
            a_r22_reg <= r22;
        end
        b_ss_reg      <= ss_next;
        b_lock_reg    <= lock_next;
        b_pneg_reg    <= (a_r20_reg > 0);
        b_s_reg       <= -XW'(a_r20_reg);
        b_yaw_reg     <= yaw_next;
        b_roll_reg    <= roll_next;
        q_rem_reg[0]  <= ONE_SQ - b_ss_reg[VW-1:0];
        q_root_reg[0] <= '0;
        q_lock_reg[0] <= b_lock_reg;
        q_pneg_reg[0] <= b_pneg_reg;
        q_s_reg[0]    <= b_s_reg;
        q_yaw_reg[0]  <= b_yaw_reg;
        q_roll_reg[0] <= b_roll_reg;
        req_reg       <= req_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            q_valid_reg[0] <= 1'b0;
            req_valid_reg  <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= accept;
            b_valid_reg    <= a_valid_reg;
            q_valid_reg[0] <= b_valid_reg;
            req_valid_reg  <= q_valid_reg[NS];
        end
    end

    // restoring square root, one result bit per stage, most significant first
    for (genvar j = 0; j < NS; j++)
    begin : g_sqrt
        localparam int K = M - 2 - j;
        logic [VW:0]   trial;
        logic [VW-1:0] rem_next;
        logic [RW-1:0] root_next;

        always_comb
        begin
            trial     = ((VW+1)'(q_root_reg[j]) << (K + 1)) + ((VW+1)'(1) << (2 * K));
            rem_next  = q_rem_reg[j];
            root_next = q_root_reg[j];
            if ({1'b0, q_rem_reg[j]} >= trial)
            begin
                rem_next  = q_rem_reg[j] - trial[VW-1:0];
                root_next = q_root_reg[j] | (RW'(1) << K);
            end
        end

        always_ff @(posedge clk)
        begin
            q_rem_reg[j+1]  <= rem_next;
            q_root_reg[j+1] <= root_next;
            q_lock_reg[j+1] <= q_lock_reg[j];
            q_pneg_reg[j+1] <= q_pneg_reg[j];
            q_s_reg[j+1]    <= q_s_reg[j];
            q_yaw_reg[j+1]  <= q_yaw_reg[j];
            q_roll_reg[j+1] <= q_roll_reg[j];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q_valid_reg[j+1] <= 1'b0;
            end
            else
            begin
                q_valid_reg[j+1] <= q_valid_reg[j];
            end
        end
    end

    // pitch = atan2(s, sqrt(1 - s*s)); the root is never zero off the lock branch
    always_comb
    begin
        req_next.yaw  = q_yaw_reg[NS];
        req_next.roll = q_roll_reg[NS];
        req_next.lock = q_lock_reg[NS];
        if (q_lock_reg[NS])
        begin
            req_next.pitch = fixed_job(q_pneg_reg[NS] ? -PIH_Z : PIH_Z);
        end
        else
        begin
            req_next.pitch = full_atan2_job(q_s_reg[NS], XW'(q_root_reg[NS]));
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

endmodule

@@ rtl/core/rmze_queue.sv @@
// Short request queue between the front end and the CORDIC back end.
module rmze_queue
    import rmze_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  euler_req_t push_data,
    input  logic       pop,
    output euler_req_t pop_data,
    output logic       empty,
    output logic       full
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    euler_req_t    slot_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    assign pop_data = slot_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (AW+1)'(QUEUE_DEPTH));

endmodule

@@ rtl/core/rmze_back.sv @@
// Back end: three pipelined vectoring CORDIC lanes, rounding and saturation of the angles.
module rmze_back
    import rmze_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 16,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  euler_req_t                    req,
    output logic                          done,
    output logic signed [ANGLE_WIDTH-1:0] yaw_angle,
    output logic signed [ANGLE_WIDTH-2:0] pitch_angle,
    output logic signed [ANGLE_WIDTH-2:0] roll_angle,
    output logic                          gimbal_lock
);

    localparam int A   = ANGLE_WIDTH;
    localparam int N   = CORDIC_STAGES;
    localparam int PRE = 60 - MATRIX_WIDTH;
    localparam int SH  = ZFRAC - (A - 3);
    localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (SH - 1);
    localparam logic signed [ZW-1:0] PI_LIM  = (PI_Z + HALF) >>> SH;
    localparam logic signed [ZW-1:0] PIH_LIM = (PIH_Z + HALF) >>> SH;

    cordic_lane_t st_reg [N+1][3];
    logic         vld_reg  [N+1];
    logic         lock_reg [N+1];

    logic                 done_reg;
    logic signed [A-1:0]  yaw_reg;
    logic signed [A-2:0]  pitch_reg, roll_reg;
    logic                 lock_out_reg;

    atan_job_t            job [3];
    logic signed [ZW-1:0] rnd [3];
    logic signed [ZW-1:0] sat [3];

    assign job[0] = req.yaw;
    assign job[1] = req.pitch;
    assign job[2] = req.roll;

    // load: prescale the operands, seed the accumulator with the quadrant offset
    for (genvar l = 0; l < 3; l++)
    begin : g_load
        always_ff @(posedge clk)
        begin
            st_reg[0][l].bypass <= job[l].bypass;
            st_reg[0][l].x      <= CW'(job[l].x) <<< PRE;
            st_reg[0][l].y      <= CW'(job[l].y) <<< PRE;
            st_reg[0][l].z      <= job[l].base;
        end
    end

    always_ff @(posedge clk)
    begin
        lock_reg[0] <= req.lock;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= req_valid;
        end
    end

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_TAB[i]);

        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            cordic_lane_t cur, nxt;
            logic signed [CW-1:0] xs, ys;

            always_comb
            begin
                cur = st_reg[i][l];
                nxt = cur;
                xs  = cur.x >>> i;
                ys  = cur.y >>> i;
                if (!cur.bypass)
                begin
                    if (cur.y >= 0)
                    begin
                        nxt.x = cur.x + ys;
                        nxt.y = cur.y - xs;
                        nxt.z = cur.z + ANG;
                    end
                    else
                    begin
                        nxt.x = cur.x - ys;
                        nxt.y = cur.y + xs;
                        nxt.z = cur.z - ANG;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                st_reg[i+1][l] <= nxt;
            end
        end

        always_ff @(posedge clk)
        begin
            lock_reg[i+1] <= lock_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end
    end

    // round half up to the output grid, then clamp to +/-pi (yaw) or +/-pi/2
    for (genvar l = 0; l < 3; l++)
    begin : g_out
        logic signed [ZW-1:0] lim;
        assign lim    = (l == 0) ? PI_LIM : PIH_LIM;
        assign rnd[l] = (st_reg[N][l].z + HALF) >>> SH;
        assign sat[l] = (rnd[l] > lim) ? lim : ((rnd[l] < -lim) ? -lim : rnd[l]);
    end

    always_ff @(posedge clk)
    begin
        yaw_reg      <= sat[0][A-1:0];
        pitch_reg    <= sat[1][A-2:0];
        roll_reg     <= sat[2][A-2:0];
        lock_out_reg <= lock_reg[N];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[N];
        end
    end

    assign done        = done_reg;
    assign yaw_angle   = yaw_reg;
    assign pitch_angle = pitch_reg;
    assign roll_angle  = roll_reg;
    assign gimbal_lock = lock_out_reg;

endmodule

@@ rtl/core/rotation_matrix_to_zyx_euler.sv @@
// Top level of the rotation matrix to ZYX Euler angle converter.
//
// Converts seven entries of a 3x3 rotation matrix (signed Q2.14 at the default
// MATRIX_WIDTH) into yaw in signed Q3.13 radians and pitch and roll in signed
// Q2.13 radians. A request is taken on any clock edge with start high and busy
// low; one matrix can enter every cycle. Each request gives exactly one result,
// shown for a single cycle with done high, in request order. The receiver cannot
// hold results off, so latch them when done is seen. A matrix passes through the
// front end (capture, square and branch choice, a square root that settles one
// root bit per stage, request register), the queue, and the back end (operand
// load, one CORDIC iteration per stage, rounding and clamping). The back end
// drains the queue every cycle, so busy stays low in normal use. When |r20|
// reaches one, the gimbal-lock branch is taken: roll is zero, pitch is -pi/2 or
// +pi/2 by the sign of r20, yaw comes from r01 and r11, and gimbal_lock is set.
module rotation_matrix_to_zyx_euler
    import rmze_pkg::*;
#(
    parameter int MATRIX_WIDTH  = 16,
    parameter int ANGLE_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [MATRIX_WIDTH-1:0] r00,
    input  logic signed [MATRIX_WIDTH-1:0] r01,
    input  logic signed [MATRIX_WIDTH-1:0] r10,
    input  logic signed [MATRIX_WIDTH-1:0] r11,
    input  logic signed [MATRIX_WIDTH-1:0] r20,
    input  logic signed [MATRIX_WIDTH-1:0] r21,
    input  logic signed [MATRIX_WIDTH-1:0] r22,
    output logic                           done,
    output logic signed [ANGLE_WIDTH-1:0]  yaw_angle,
    output logic signed [ANGLE_WIDTH-2:0]  pitch_angle,
    output logic signed [ANGLE_WIDTH-2:0]  roll_angle,
    output logic                           gimbal_lock
);

    logic       accept;
    logic       front_valid;
    euler_req_t front_req;
    euler_req_t queue_req;
    logic       queue_empty;
    logic       queue_full;
    logic       queue_pop;

    // take a request whenever the queue has room
    assign busy   = queue_full;
    assign accept = start && !busy;

    rmze_front #(
        .MATRIX_WIDTH (MATRIX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .r00       (r00),
        .r01       (r01),
        .r10       (r10),
        .r11       (r11),
        .r20       (r20),
        .r21       (r21),
        .r22       (r22),
        .req_valid (front_valid),
        .req       (front_req)
    );

    // drain one request per cycle into the CORDIC pipeline
    assign queue_pop = !queue_empty;

    rmze_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_req),
        .pop       (queue_pop),
        .pop_data  (queue_req),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    rmze_back #(
        .MATRIX_WIDTH  (MATRIX_WIDTH),
        .ANGLE_WIDTH   (ANGLE_WIDTH),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (queue_pop),
        .req         (queue_req),
        .done        (done),
        .yaw_angle   (yaw_angle),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle),
        .gimbal_lock (gimbal_lock)
    );

endmodule
